// ===== design/hrp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrp_pkg
// shared types, codes and helper functions of the http request header parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrp_pkg;

  // default depth of the held whitespace store
  localparam int HELD_SPACE_MAX_DEF = 16;
  // width of a held whitespace count or index (covers depths up to 63)
  localparam int HC_W = 6;
  // entries in the command queue between front and back
  localparam int CMD_DEPTH = 4;

  // token kinds
  localparam logic [2:0] KIND_METHOD = 3'd0;
  localparam logic [2:0] KIND_PATH   = 3'd1;
  localparam logic [2:0] KIND_KEY    = 3'd2;
  localparam logic [2:0] KIND_VALUE  = 3'd3;
  localparam logic [2:0] KIND_PAIR   = 3'd4;
  localparam logic [2:0] KIND_STATUS = 3'd5;

  // status codes
  localparam logic [7:0] STAT_COMPLETE   = 8'd0;
  localparam logic [7:0] STAT_INCOMPLETE = 8'd1;
  localparam logic [7:0] STAT_MALFORMED  = 8'd2;
  localparam logic [7:0] STAT_OVERFLOW   = 8'd3;

  // characters
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [2:0] MLEN_SAT = 3'd7;

  typedef enum logic [2:0] {
    PH_METHOD = 3'd0,
    PH_PATH   = 3'd1,
    PH_REST   = 3'd2,
    PH_KEY    = 3'd3,
    PH_VALUE  = 3'd4
  } phase_t;

  // operation of one command slot
  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_EMIT    = 2'd1,
    OP_HOLD    = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  // steps of one command in the back end
  typedef enum logic [1:0] {
    STEP_PRE  = 2'd0,
    STEP_REL  = 2'd1,
    STEP_MAIN = 2'd2,
    STEP_STAT = 2'd3
  } step_t;

  // one command per input byte
  typedef struct packed {
    op_t              pre_op;
    logic [2:0]       pre_kind;
    logic [7:0]       pre_data;
    logic [HC_W-1:0]  pre_idx;
    op_t              main_op;
    logic [2:0]       main_kind;
    logic [7:0]       main_data;
    logic [HC_W-1:0]  main_idx;
    logic             stat_en;
    logic [7:0]       stat_data;
  } cmd_t;

  typedef struct packed {
    op_t             op;
    logic [7:0]      data;
    logic [HC_W-1:0] idx;
    logic [HC_W-1:0] h_next;
    logic            ts_next;
    logic            ovf;
  } feed_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_LF) || (b == CH_CR) || (b == CH_TAB) ||
           (b == CH_FF) || (b == CH_VT);
  endfunction

  function automatic logic [2:0] method_len(input logic [2:0] i);
    logic [2:0] r;
    case (i)
      3'd0: r = 3'd7;
      3'd1: r = 3'd3;
      3'd2: r = 3'd4;
      3'd3: r = 3'd4;
      3'd4: r = 3'd3;
      3'd5: r = 3'd6;
      3'd6: r = 3'd5;
      3'd7: r = 3'd7;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] method_char(input logic [2:0] i, input logic [2:0] pos);
    logic [55:0] s;
    logic [55:0] t;
    case (i)
      3'd0: s = "OPTIONS";
      3'd1: s = {"GET", 32'h0};
      3'd2: s = {"HEAD", 24'h0};
      3'd3: s = {"POST", 24'h0};
      3'd4: s = {"PUT", 32'h0};
      3'd5: s = {"DELETE", 8'h0};
      3'd6: s = {"TRACE", 16'h0};
      3'd7: s = "CONNECT";
      default: s = 56'h0;
    endcase
    t = s << {pos, 3'b000};
    return t[55:48];
  endfunction

  // one byte into a key or value: drop leading whitespace, hold later whitespace, or release held bytes and the byte
  function automatic feed_t feed(input logic [7:0] b, input logic [2:0] kind,
                                 input logic [HC_W-1:0] h, input logic ts,
                                 input logic [HC_W-1:0] hmax);
    feed_t r;
    r.op      = OP_NONE;
    r.data    = b;
    r.idx     = h;
    r.h_next  = h;
    r.ts_next = ts;
    r.ovf     = 1'b0;
    if (is_ws(b)) begin
      if (ts) begin
        if (h >= hmax) begin
          r.ovf = 1'b1;
        end else begin
          r.op     = OP_HOLD;
          r.h_next = h + 1'b1;
        end
      end
    end else begin
      r.op      = OP_RELEASE;
      r.h_next  = '0;
      r.ts_next = 1'b1;
      if (kind == KIND_KEY && b >= CH_UA && b <= CH_UZ) begin
        r.data = b + CASE_OFS;
      end
    end
    return r;
  endfunction

endpackage

// ===== design/hrp_in_if.sv =====
// ----------------------------------------------------------------------------
// hrp_in_if
// request byte channel, valid / ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_request;

  modport source (output valid, output byte_in, output end_of_request, input ready);
  modport sink   (input valid, input byte_in, input end_of_request, output ready);
endinterface

// ===== design/hrp_out_if.sv =====
// ----------------------------------------------------------------------------
// hrp_out_if
// token channel, valid / ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hrp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [7:0] token_data;
  logic       run_last;

  modport source (output valid, output token_kind, output token_data, output run_last,
                  input ready);
  modport sink   (input valid, input token_kind, input token_data, input run_last,
                  output ready);
endinterface

// ===== design/hrp_ram.sv =====
// ----------------------------------------------------------------------------
// hrp_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/hrp_front.sv =====
// ----------------------------------------------------------------------------
// hrp_front
// byte classifier: request line and header state, one command per byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrp_front #(
  parameter int HELD_SPACE_MAX = hrp_pkg::HELD_SPACE_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst,
  hrp_in_if.sink        req,
  output logic          push,
  output hrp_pkg::cmd_t push_cmd,
  input  logic          full
);

  localparam logic [hrp_pkg::HC_W-1:0] HMAX = hrp_pkg::HC_W'(HELD_SPACE_MAX);

  hrp_pkg::phase_t           phase, phase_next;
  logic [7:0]                method_match, method_match_next;
  logic [2:0]                method_length, method_length_next;
  logic [hrp_pkg::HC_W-1:0]  held_count, held_count_next;
  logic                      token_started, token_started_next;
  logic                      line_empty, line_empty_next;
  logic                      decided, decided_next;
  logic                      cr_wait, cr_wait_next;
  logic                      accept;
  hrp_pkg::cmd_t             c;

  assign req.ready = !full;
  assign accept    = req.valid && !full;
  assign push_cmd  = c;
  assign push      = accept && ((c.pre_op != hrp_pkg::OP_NONE) ||
                                (c.main_op != hrp_pkg::OP_NONE) || c.stat_en);

  always_comb begin
    hrp_pkg::feed_t f1;
    hrp_pkg::feed_t f2;
    logic           stop;
    logic           found;
    logic [2:0]     code;
    logic [7:0]     mask;
    logic [7:0]     b;

    b     = req.byte_in;
    stop  = 1'b0;
    found = 1'b0;
    code  = '0;
    mask  = '0;
    f1    = hrp_pkg::feed(hrp_pkg::CH_CR, hrp_pkg::KIND_KEY, '0, 1'b0, HMAX);
    f2    = f1;

    phase_next         = phase;
    method_match_next  = method_match;
    method_length_next = method_length;
    held_count_next    = held_count;
    token_started_next = token_started;
    line_empty_next    = line_empty;
    decided_next       = decided;
    cr_wait_next       = cr_wait;

    c.pre_op    = hrp_pkg::OP_NONE;
    c.pre_kind  = '0;
    c.pre_data  = '0;
    c.pre_idx   = '0;
    c.main_op   = hrp_pkg::OP_NONE;
    c.main_kind = '0;
    c.main_data = '0;
    c.main_idx  = '0;
    c.stat_en   = 1'b0;
    c.stat_data = '0;

    if (!decided) begin
      case (phase)
        hrp_pkg::PH_METHOD: begin
          if (b == hrp_pkg::CH_SP) begin
            for (int i = 7; i >= 0; i--) begin
              if (method_match[i] && hrp_pkg::method_len(3'(i)) == method_length) begin
                found = 1'b1;
                code  = 3'(i);
              end
            end
            if (found) begin
              c.main_op   = hrp_pkg::OP_EMIT;
              c.main_kind = hrp_pkg::KIND_METHOD;
              c.main_data = {5'b0, code};
              phase_next  = hrp_pkg::PH_PATH;
            end else begin
              c.stat_en    = 1'b1;
              c.stat_data  = hrp_pkg::STAT_MALFORMED;
              decided_next = 1'b1;
            end
          end else begin
            for (int i = 0; i < 8; i++) begin
              mask[i] = method_match[i] && (method_length < hrp_pkg::method_len(3'(i))) &&
                        (hrp_pkg::method_char(3'(i), method_length) == b);
            end
            method_match_next = mask;
            if (method_length < hrp_pkg::MLEN_SAT) begin
              method_length_next = method_length + 1'b1;
            end
            if (mask == '0) begin
              c.stat_en    = 1'b1;
              c.stat_data  = hrp_pkg::STAT_MALFORMED;
              decided_next = 1'b1;
            end
          end
        end

        hrp_pkg::PH_PATH: begin
          if (cr_wait) begin
            cr_wait_next = 1'b0;
            if (b == hrp_pkg::CH_LF) begin
              c.stat_en    = 1'b1;
              c.stat_data  = hrp_pkg::STAT_MALFORMED;
              decided_next = 1'b1;
              stop         = 1'b1;
            end else begin
              c.pre_op   = hrp_pkg::OP_EMIT;
              c.pre_kind = hrp_pkg::KIND_PATH;
              c.pre_data = hrp_pkg::CH_CR;
            end
          end
          if (!stop) begin
            if (b == hrp_pkg::CH_SP) begin
              phase_next = hrp_pkg::PH_REST;
            end else if (b == hrp_pkg::CH_CR) begin
              cr_wait_next = 1'b1;
            end else begin
              c.main_op   = hrp_pkg::OP_EMIT;
              c.main_kind = hrp_pkg::KIND_PATH;
              c.main_data = b;
            end
          end
        end

        hrp_pkg::PH_REST: begin
          if (cr_wait && b == hrp_pkg::CH_LF) begin
            cr_wait_next       = 1'b0;
            phase_next         = hrp_pkg::PH_KEY;
            line_empty_next    = 1'b1;
            token_started_next = 1'b0;
            held_count_next    = '0;
          end else begin
            cr_wait_next = (b == hrp_pkg::CH_CR);
          end
        end

        hrp_pkg::PH_KEY: begin
          if (cr_wait) begin
            cr_wait_next = 1'b0;
            if (b == hrp_pkg::CH_LF) begin
              c.stat_en    = 1'b1;
              c.stat_data  = line_empty ? hrp_pkg::STAT_COMPLETE : hrp_pkg::STAT_MALFORMED;
              decided_next = 1'b1;
              stop         = 1'b1;
            end else begin
              line_empty_next    = 1'b0;
              f1 = hrp_pkg::feed(hrp_pkg::CH_CR, hrp_pkg::KIND_KEY, held_count,
                                 token_started, HMAX);
              c.pre_op           = f1.op;
              c.pre_kind         = hrp_pkg::KIND_KEY;
              c.pre_data         = f1.data;
              c.pre_idx          = f1.idx;
              held_count_next    = f1.h_next;
              token_started_next = f1.ts_next;
              if (f1.ovf) begin
                c.stat_en    = 1'b1;
                c.stat_data  = hrp_pkg::STAT_OVERFLOW;
                decided_next = 1'b1;
                stop         = 1'b1;
              end
            end
          end
          if (!stop) begin
            if (b == hrp_pkg::CH_CR) begin
              cr_wait_next = 1'b1;
            end else begin
              line_empty_next = 1'b0;
              if (b == hrp_pkg::CH_COLON) begin
                held_count_next    = '0;
                token_started_next = 1'b0;
                phase_next         = hrp_pkg::PH_VALUE;
              end else begin
                f2 = hrp_pkg::feed(b, hrp_pkg::KIND_KEY, held_count_next,
                                   token_started_next, HMAX);
                c.main_op          = f2.op;
                c.main_kind        = hrp_pkg::KIND_KEY;
                c.main_data        = f2.data;
                c.main_idx         = f2.idx;
                held_count_next    = f2.h_next;
                token_started_next = f2.ts_next;
                if (f2.ovf) begin
                  c.stat_en    = 1'b1;
                  c.stat_data  = hrp_pkg::STAT_OVERFLOW;
                  decided_next = 1'b1;
                end
              end
            end
          end
        end

        hrp_pkg::PH_VALUE: begin
          if (cr_wait) begin
            cr_wait_next = 1'b0;
            if (b == hrp_pkg::CH_LF) begin
              c.main_op          = hrp_pkg::OP_EMIT;
              c.main_kind        = hrp_pkg::KIND_PAIR;
              c.main_data        = '0;
              phase_next         = hrp_pkg::PH_KEY;
              line_empty_next    = 1'b1;
              token_started_next = 1'b0;
              held_count_next    = '0;
              stop               = 1'b1;
            end else begin
              f1 = hrp_pkg::feed(hrp_pkg::CH_CR, hrp_pkg::KIND_VALUE, held_count,
                                 token_started, HMAX);
              c.pre_op           = f1.op;
              c.pre_kind         = hrp_pkg::KIND_VALUE;
              c.pre_data         = f1.data;
              c.pre_idx          = f1.idx;
              held_count_next    = f1.h_next;
              token_started_next = f1.ts_next;
              if (f1.ovf) begin
                c.stat_en    = 1'b1;
                c.stat_data  = hrp_pkg::STAT_OVERFLOW;
                decided_next = 1'b1;
                stop         = 1'b1;
              end
            end
          end
          if (!stop) begin
            if (b == hrp_pkg::CH_CR) begin
              cr_wait_next = 1'b1;
            end else begin
              f2 = hrp_pkg::feed(b, hrp_pkg::KIND_VALUE, held_count_next,
                                 token_started_next, HMAX);
              c.main_op          = f2.op;
              c.main_kind        = hrp_pkg::KIND_VALUE;
              c.main_data        = f2.data;
              c.main_idx         = f2.idx;
              held_count_next    = f2.h_next;
              token_started_next = f2.ts_next;
              if (f2.ovf) begin
                c.stat_en    = 1'b1;
                c.stat_data  = hrp_pkg::STAT_OVERFLOW;
                decided_next = 1'b1;
              end
            end
          end
        end

        default: begin
          phase_next = hrp_pkg::PH_METHOD;
        end
      endcase
    end

    // end of request: close with a status if none yet, then back to reset state
    if (req.end_of_request) begin
      if (!decided_next) begin
        c.stat_en   = 1'b1;
        c.stat_data = ((phase_next == hrp_pkg::PH_METHOD) || (phase_next == hrp_pkg::PH_PATH) ||
                       (phase_next == hrp_pkg::PH_REST)) ? hrp_pkg::STAT_MALFORMED
                                                         : hrp_pkg::STAT_INCOMPLETE;
      end
      phase_next         = hrp_pkg::PH_METHOD;
      method_match_next  = 8'hFF;
      method_length_next = '0;
      held_count_next    = '0;
      token_started_next = 1'b0;
      line_empty_next    = 1'b1;
      decided_next       = 1'b0;
      cr_wait_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= hrp_pkg::PH_METHOD;
      method_match  <= 8'hFF;
      method_length <= '0;
      held_count    <= '0;
      token_started <= 1'b0;
      line_empty    <= 1'b1;
      decided       <= 1'b0;
      cr_wait       <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      method_match  <= method_match_next;
      method_length <= method_length_next;
      held_count    <= held_count_next;
      token_started <= token_started_next;
      line_empty    <= line_empty_next;
      decided       <= decided_next;
      cr_wait       <= cr_wait_next;
    end
  end

endmodule

// ===== design/hrp_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// hrp_cmd_fifo
// short command queue between classifier and token sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrp_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hrp_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output hrp_pkg::cmd_t head,
  output logic          empty
);

  localparam int PW = (hrp_pkg::CMD_DEPTH > 1) ? $clog2(hrp_pkg::CMD_DEPTH) : 1;
  localparam int CW = $clog2(hrp_pkg::CMD_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(hrp_pkg::CMD_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(hrp_pkg::CMD_DEPTH);

  hrp_pkg::cmd_t  slots [hrp_pkg::CMD_DEPTH];
  logic [PW-1:0]  wp;
  logic [PW-1:0]  rp;
  logic [CW-1:0]  count;

  assign full  = (count == CNT_FULL);
  assign empty = (count == '0);
  assign head  = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PTR_LAST) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PTR_LAST) ? '0 : rp + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/hrp_back.sv =====
// ----------------------------------------------------------------------------
// hrp_back
// token sequencer: holds and releases whitespace, drives the token register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrp_back #(
  parameter int HELD_SPACE_MAX = hrp_pkg::HELD_SPACE_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  hrp_pkg::cmd_t head,
  input  logic          cmd_valid,
  output logic          pop,
  hrp_out_if.source     tok
);

  localparam int AW = (HELD_SPACE_MAX > 1) ? $clog2(HELD_SPACE_MAX) : 1;

  hrp_pkg::step_t           ptr, ptr_next;
  logic [hrp_pkg::HC_W-1:0] rel_i, rel_i_next;
  logic                     primed, primed_next;

  logic                     out_valid;
  logic [2:0]               out_kind;
  logic [7:0]               out_data;
  logic                     out_last;
  logic                     out_free;

  logic                     emit;
  logic [2:0]               emit_kind;
  logic [7:0]               emit_data;
  logic                     emit_last;

  logic                     we;
  logic [AW-1:0]            waddr;
  logic [7:0]               wdata;
  logic                     re;
  logic [AW-1:0]            raddr;
  logic [7:0]               rdata;

  logic [3:0]               has;
  logic [3:0]               tok_steps;
  logic [3:0]               avail;
  logic [3:0]               later;
  hrp_pkg::step_t           eff;
  logic                     done_step;

  assign out_free      = !out_valid || tok.ready;
  assign tok.valid      = out_valid;
  assign tok.token_kind = out_kind;
  assign tok.token_data = out_data;
  assign tok.run_last   = out_last;

  hrp_ram #(
    .WIDTH (8),
    .DEPTH (HELD_SPACE_MAX),
    .AW    (AW)
  ) u_held (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // which steps of the head command are present, and which make a token
  always_comb begin
    has[0] = (head.pre_op != hrp_pkg::OP_NONE);
    has[1] = (head.main_op == hrp_pkg::OP_RELEASE) && (head.main_idx != '0);
    has[2] = (head.main_op != hrp_pkg::OP_NONE);
    has[3] = head.stat_en;
    tok_steps[0] = (head.pre_op == hrp_pkg::OP_EMIT);
    tok_steps[1] = has[1];
    tok_steps[2] = (head.main_op == hrp_pkg::OP_EMIT) || (head.main_op == hrp_pkg::OP_RELEASE);
    tok_steps[3] = head.stat_en;
    avail = has & ~((4'b0001 << ptr) - 4'b0001);
    eff   = hrp_pkg::STEP_STAT;
    for (int i = 3; i >= 0; i--) begin
      if (avail[i]) begin
        eff = hrp_pkg::step_t'(2'(i));
      end
    end
    later = avail & ~((4'b0010 << eff) - 4'b0001);
  end

  always_comb begin
    ptr_next    = ptr;
    rel_i_next  = rel_i;
    primed_next = primed;
    done_step   = 1'b0;
    emit        = 1'b0;
    emit_kind   = '0;
    emit_data   = '0;
    emit_last   = !(|(later & tok_steps));
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    re          = 1'b0;
    raddr       = rel_i[AW-1:0];
    pop         = 1'b0;

    if (cmd_valid) begin
      case (eff)
        hrp_pkg::STEP_PRE: begin
          if (head.pre_op == hrp_pkg::OP_HOLD) begin
            we        = 1'b1;
            waddr     = head.pre_idx[AW-1:0];
            wdata     = head.pre_data;
            done_step = 1'b1;
          end else if (out_free) begin
            emit      = 1'b1;
            emit_kind = head.pre_kind;
            emit_data = head.pre_data;
            done_step = 1'b1;
          end
        end

        hrp_pkg::STEP_REL: begin
          // starts the read burst first, then one held byte a cycle while the token output is free
          if (!primed) begin
            re          = 1'b1;
            raddr       = rel_i[AW-1:0];
            primed_next = 1'b1;
          end else if (out_free) begin
            emit      = 1'b1;
            emit_kind = head.main_kind;
            emit_data = rdata;
            if (rel_i + 1'b1 < head.main_idx) begin
              re         = 1'b1;
              raddr      = rel_i[AW-1:0] + 1'b1;
              rel_i_next = rel_i + 1'b1;
            end else begin
              rel_i_next  = '0;
              primed_next = 1'b0;
              done_step   = 1'b1;
            end
          end
        end

        hrp_pkg::STEP_MAIN: begin
          if (head.main_op == hrp_pkg::OP_HOLD) begin
            we        = 1'b1;
            waddr     = head.main_idx[AW-1:0];
            wdata     = head.main_data;
            done_step = 1'b1;
          end else if (out_free) begin
            emit      = 1'b1;
            emit_kind = head.main_kind;
            emit_data = head.main_data;
            done_step = 1'b1;
          end
        end

        hrp_pkg::STEP_STAT: begin
          if (out_free) begin
            emit      = 1'b1;
            emit_kind = hrp_pkg::KIND_STATUS;
            emit_data = head.stat_data;
            done_step = 1'b1;
          end
        end

        default: begin
          done_step = 1'b0;
        end
      endcase

      if (done_step) begin
        if (later == '0) begin
          pop      = 1'b1;
          ptr_next = hrp_pkg::STEP_PRE;
        end else begin
          ptr_next = hrp_pkg::step_t'(eff + 2'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= hrp_pkg::STEP_PRE;
      rel_i     <= '0;
      primed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      ptr    <= ptr_next;
      rel_i  <= rel_i_next;
      primed <= primed_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (tok.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind <= emit_kind;
      out_data <= emit_data;
      out_last <= emit_last;
    end
  end

endmodule

// ===== design/http_request_header_parser.sv =====
// ----------------------------------------------------------------------------
// http_request_header_parser
// streaming http/1.1 request header parser, one request byte per beat
// ----------------------------------------------------------------------------
// A request byte is accepted whenever the command queue has a free slot; a
// byte that causes no token and holds no whitespace takes no further time.
// Each token then passes through the token sequencer, a byte of held
// whitespace is stored in the held store ram, and a release of held
// whitespace first starts a read burst from that ram. While the token output
// is not stalled, held bytes then leave at one per cycle, and the sustained
// rate, set by the token sequencer, is one byte per cycle for ordinary text.
// The held store needs no clearing pass after reset. Tokens emitted before a
// status other than complete belong to a request that must be discarded
// downstream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module http_request_header_parser #(
  parameter int HELD_SPACE_MAX = hrp_pkg::HELD_SPACE_MAX_DEF
) (
  input logic        clk,
  input logic        rst,
  hrp_in_if.sink     req,
  hrp_out_if.source  tok
);

  // command path from classifier to sequencer
  logic          push;
  hrp_pkg::cmd_t push_cmd;
  logic          full;
  logic          pop;
  hrp_pkg::cmd_t head;
  logic          empty;

  // classifier: tracks method, path, header line state per request byte
  hrp_front #(
    .HELD_SPACE_MAX (HELD_SPACE_MAX)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full)
  );

  // short queue so that input can go on during a whitespace release burst until the queue is full
  hrp_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  // sequencer: stores held whitespace, emits tokens with the last-of-beat flag
  hrp_back #(
    .HELD_SPACE_MAX (HELD_SPACE_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .cmd_valid (!empty),
    .pop       (pop),
    .tok       (tok)
  );

endmodule
